// ----- hw/rtl/ccbb_pkg.sv -----
// ccbb_pkg: shared types, register indexes and field widths for the
// connected-component bounding box block. No dependencies.
package ccbb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA     = 2'd3;

    localparam int FRAME_DIM_W = 11;
    localparam int BORDER_W    = 8;
    localparam int MIN_AREA_W  = 21;

    localparam int BOX_X_W = 10;
    localparam int BOX_Y_W = 10;
    localparam int BOX_W_W = 11;
    localparam int BOX_H_W = 11;

    localparam int MIN_FRAME_W = 3;
    localparam int MIN_FRAME_H = 2;

    localparam int QUEUE_DEPTH = 4;

    // Per-pixel classification passed from the front to the back.
    typedef struct packed {
        logic lab;        // pixel takes part in labeling
        logic has_ur;     // an upper-right neighbor exists
        logic end_row;
        logic end_frame;
    } t_pix_ctl;

    typedef struct packed {
        logic [BOX_X_W-1:0] x;
        logic [BOX_Y_W-1:0] y;
        logic [BOX_W_W-1:0] w;
        logic [BOX_H_W-1:0] h;
    } t_box;

    // Width of geometry arithmetic: holds frame sizes, coordinates plus
    // twice the border, and the 11-bit size registers.
    function automatic int calc_w(int max_w, int max_h);
        int m;
        m = FRAME_DIM_W;
        if ($clog2(max_w + 1) > m) m = $clog2(max_w + 1);
        if ($clog2(max_h + 1) > m) m = $clog2(max_h + 1);
        return m + 2;
    endfunction

endpackage

// ----- hw/rtl/connected_component_bounding_boxes.sv -----
// connected_component_bounding_boxes: top level, configuration registers,
// pixel front, queue and labeling back. Depends on ccbb_pkg, ccbb_front,
// ccbb_fifo, ccbb_back.
//
// Channel   Direction  Handshake                  Payload
// pixel     in         i_pix_valid / o_pix_ready  i_foreground
// result    out        o_res_valid / i_res_ready  o_box_*, o_last_box, overflow flags
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// In the back, a pixel that needs no labeling passes S_IDLE, S_UP, S_UR and
// S_LINE; a pixel with labeling adds the parent and extent RAM reads of the
// root search and merge. A four-entry queue lets the front keep accepting.
// Frame end walks the label table twice: once to count roots, once to
// choose and emit boxes. Reset is synchronous, active low; no clearing
// pass is needed. Output stalls hold the back; the front stalls when the queue fills.
module connected_component_bounding_boxes #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_LABELS = 256,
    parameter int MAX_BOXES  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pix_valid,
    output logic                              o_pix_ready,
    input  logic                              i_foreground,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [ccbb_pkg::BOX_X_W-1:0]      o_box_x,
    output logic [ccbb_pkg::BOX_Y_W-1:0]      o_box_y,
    output logic [ccbb_pkg::BOX_W_W-1:0]      o_box_width,
    output logic [ccbb_pkg::BOX_H_W-1:0]      o_box_height,
    output logic                              o_box_valid,
    output logic                              o_last_box,
    output logic                              o_label_overflow,
    output logic                              o_box_overflow,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ccbb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ccbb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int CALC_W = ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int QW     = $bits(ccbb_pkg::t_pix_ctl) + XW + YW;

    logic [ccbb_pkg::FRAME_DIM_W-1:0] r_frame_width, r_frame_height;
    logic [ccbb_pkg::BORDER_W-1:0]    r_border;
    logic [ccbb_pkg::MIN_AREA_W-1:0]  r_min_area;
    logic [CALC_W-1:0]                w_fw, w_fh, w_eff_w, w_eff_h;
    logic                             w_cfg_wr, w_clr;
    logic                             w_push, w_full, w_pop, w_empty;
    logic [XW-1:0]                    w_fx, w_bx;
    logic [YW-1:0]                    w_fy, w_by;
    ccbb_pkg::t_pix_ctl               w_fctl, w_bctl;
    logic [QW-1:0]                    w_qin, w_qout;
    ccbb_pkg::t_box                   w_box;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    // A frame size write restarts the frame.
    assign w_clr = w_cfg_wr && (i_cfg_index == ccbb_pkg::CFG_FRAME_WIDTH ||
                                i_cfg_index == ccbb_pkg::CFG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 11'd640;
            r_frame_height <= 11'd480;
            r_border       <= 8'd4;
            r_min_area     <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                ccbb_pkg::CFG_FRAME_WIDTH:
                    r_frame_width  <= i_cfg_data[ccbb_pkg::FRAME_DIM_W-1:0];
                ccbb_pkg::CFG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[ccbb_pkg::FRAME_DIM_W-1:0];
                ccbb_pkg::CFG_BORDER_SIZE:
                    r_border       <= i_cfg_data[ccbb_pkg::BORDER_W-1:0];
                ccbb_pkg::CFG_MIN_AREA:
                    r_min_area     <= i_cfg_data[ccbb_pkg::MIN_AREA_W-1:0];
            endcase
        end
    end

    // Clamp the frame size between MIN_FRAME_W/H and MAX_WIDTH/MAX_HEIGHT.
    always_comb begin
        w_fw = CALC_W'(r_frame_width);
        w_fh = CALC_W'(r_frame_height);
        if (w_fw < CALC_W'(ccbb_pkg::MIN_FRAME_W)) begin
            w_eff_w = CALC_W'(ccbb_pkg::MIN_FRAME_W);
        end else if (w_fw > CALC_W'(MAX_WIDTH)) begin
            w_eff_w = CALC_W'(MAX_WIDTH);
        end else begin
            w_eff_w = w_fw;
        end
        if (w_fh < CALC_W'(ccbb_pkg::MIN_FRAME_H)) begin
            w_eff_h = CALC_W'(ccbb_pkg::MIN_FRAME_H);
        end else if (w_fh > CALC_W'(MAX_HEIGHT)) begin
            w_eff_h = CALC_W'(MAX_HEIGHT);
        end else begin
            w_eff_h = w_fh;
        end
    end

    ccbb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(w_clr),
        .i_eff_w(w_eff_w), .i_eff_h(w_eff_h),
        .i_pix_valid(i_pix_valid), .o_pix_ready(o_pix_ready),
        .i_foreground(i_foreground), .i_full(w_full), .o_push(w_push),
        .o_x(w_fx), .o_y(w_fy), .o_ctl(w_fctl)
    );

    assign w_qin = {w_fctl, w_fy, w_fx};
    assign {w_bctl, w_by, w_bx} = w_qout;

    ccbb_fifo #(.WIDTH(QW), .DEPTH(ccbb_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(w_clr),
        .i_push(w_push), .i_data(w_qin), .o_full(w_full),
        .i_pop(w_pop), .o_data(w_qout), .o_empty(w_empty)
    );

    ccbb_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_LABELS(MAX_LABELS), .MAX_BOXES(MAX_BOXES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clr(w_clr),
        .i_eff_w(w_eff_w), .i_eff_h(w_eff_h),
        .i_border(r_border), .i_min_area(r_min_area),
        .i_empty(w_empty), .i_x(w_bx), .i_y(w_by), .i_ctl(w_bctl), .o_pop(w_pop),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready),
        .o_box(w_box), .o_box_valid(o_box_valid), .o_last_box(o_last_box),
        .o_label_overflow(o_label_overflow), .o_box_overflow(o_box_overflow)
    );

    assign o_box_x      = w_box.x;
    assign o_box_y      = w_box.y;
    assign o_box_width  = w_box.w;
    assign o_box_height = w_box.h;
endmodule

// ----- hw/rtl/ccbb_ram.sv -----
// ccbb_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module ccbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/ccbb_fifo.sv -----
// ccbb_fifo: short register queue between the pixel front and the back.
// No dependencies.
module ccbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end
endmodule

// ----- hw/rtl/ccbb_front.sv -----
// ccbb_front: accepts pixels, tracks column and row, classifies each pixel.
// Depends on ccbb_pkg.
module ccbb_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic [ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT)-1:0] i_eff_w,
    input  logic [ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT)-1:0] i_eff_h,
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic                          i_foreground,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_x,
    output logic [$clog2(MAX_HEIGHT)-1:0] o_y,
    output ccbb_pkg::t_pix_ctl            o_ctl
);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int CALC_W = ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT);

    logic [XW-1:0]     r_col;
    logic [YW-1:0]     r_row;
    logic [CALC_W-1:0] w_col1, w_row1;
    logic              w_end_row, w_last_row;

    assign w_col1     = CALC_W'(r_col) + CALC_W'(1);
    assign w_row1     = CALC_W'(r_row) + CALC_W'(1);
    assign w_end_row  = (w_col1 >= i_eff_w);
    assign w_last_row = (w_row1 >= i_eff_h);

    assign o_pix_ready = !i_full;
    assign o_push      = i_pix_valid && !i_full;
    assign o_x         = r_col;
    assign o_y         = r_row;

    always_comb begin
        o_ctl.lab       = i_foreground && (r_row != '0) && (r_col != '0) && !w_end_row;
        o_ctl.has_ur    = !w_end_row;
        o_ctl.end_row   = w_end_row;
        o_ctl.end_frame = w_end_row && w_last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (w_end_row) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + YW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end
endmodule

// ----- hw/rtl/ccbb_back.sv -----
// ccbb_back: labels queued pixels with a union table, keeps root extents and
// walks the label table at frame end to emit boxes. Depends on ccbb_pkg, ccbb_ram.
module ccbb_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_LABELS = 256,
    parameter int MAX_BOXES  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic [ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT)-1:0] i_eff_w,
    input  logic [ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT)-1:0] i_eff_h,
    input  logic [ccbb_pkg::BORDER_W-1:0]   i_border,
    input  logic [ccbb_pkg::MIN_AREA_W-1:0] i_min_area,
    input  logic                          i_empty,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] i_y,
    input  ccbb_pkg::t_pix_ctl            i_ctl,
    output logic                          o_pop,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ccbb_pkg::t_box                o_box,
    output logic                          o_box_valid,
    output logic                          o_last_box,
    output logic                          o_label_overflow,
    output logic                          o_box_overflow
);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int LW     = $clog2(MAX_LABELS);
    localparam int NLW    = LW + 1;
    localparam int BW     = $clog2(MAX_BOXES + 2);
    localparam int CALC_W = ccbb_pkg::calc_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int AREA_W = 2 * CALC_W;
    localparam int EXW    = 2 * XW + 2 * YW;
    localparam logic [2:0]     NB_DONE  = 3'd4;
    localparam logic [NLW-1:0] LAB_LIM  = NLW'(MAX_LABELS);
    localparam logic [BW-1:0]  BOX_LIM  = BW'(MAX_BOXES);

    typedef struct packed {
        logic [XW-1:0] min_x;
        logic [XW-1:0] max_x;
        logic [YW-1:0] min_y;
        logic [YW-1:0] max_y;
    } t_ext;

    typedef enum logic [4:0] {
        S_IDLE, S_UP, S_UR, S_FIND, S_FWAIT, S_MIN, S_ACC, S_MERGE, S_MWAIT,
        S_UPD, S_LINE, S_CNT_RD, S_CNT_CHK, S_SEL_RD, S_SEL_CHK, S_GEO,
        S_GEO2, S_AREA, S_KEEP, S_FLUSH
    } t_state;

    function automatic t_ext f_merge(t_ext a, t_ext b);
        t_ext m;
        m.min_x = (b.min_x < a.min_x) ? b.min_x : a.min_x;
        m.max_x = (b.max_x > a.max_x) ? b.max_x : a.max_x;
        m.min_y = (b.min_y < a.min_y) ? b.min_y : a.min_y;
        m.max_y = (b.max_y > a.max_y) ? b.max_y : a.max_y;
        return m;
    endfunction

    t_state             r_state;
    logic [XW-1:0]      r_x;
    logic [YW-1:0]      r_y;
    ccbb_pkg::t_pix_ctl r_ctl;
    logic [LW-1:0]      r_up, r_upleft, r_left, r_cur, r_walk;
    logic [LW-1:0]      r_nb   [4];
    logic [LW-1:0]      r_root [4];
    logic [2:0]         r_i;
    t_ext               r_acc;
    logic [NLW-1:0]     r_next, r_l;
    logic               r_flag_lab, r_flag_box;
    logic [BW-1:0]      r_cnt, r_chosen;
    logic [CALC_W-1:0]  r_bx, r_by, r_ww, r_hh, r_bw, r_bh;
    logic [AREA_W-1:0]  r_area;
    logic               r_hold_v;
    ccbb_pkg::t_box     r_hold;
    logic               r_res_valid, r_res_box_valid, r_res_last, r_res_lab, r_res_bov;
    ccbb_pkg::t_box     r_res_box;

    logic              w_line_we, w_par_we, w_ext_we;
    logic [XW-1:0]     w_line_raddr;
    logic [LW-1:0]     w_line_rdata, w_par_raddr, w_par_waddr, w_par_wdata, w_par_rdata;
    logic [LW-1:0]     w_ext_raddr, w_ext_waddr, w_cur_min, w_ur, w_mroot;
    logic [EXW-1:0]    w_ext_rdata;
    t_ext              w_ext_wdata, w_ext_rd, w_pt;
    logic              w_new_ok, w_merge_hit, w_out_free;
    logic [CALC_W-1:0] w_b, w_b2, w_mnx, w_mny, w_bx, w_by, w_ww, w_hh;
    ccbb_pkg::t_box    w_box;

    assign w_ext_rd   = t_ext'(w_ext_rdata);
    assign w_pt       = '{min_x: r_x, max_x: r_x, min_y: r_y, max_y: r_y};
    assign w_ur       = r_ctl.has_ur ? w_line_rdata : '0;
    assign w_new_ok   = (r_next < LAB_LIM);
    assign w_mroot    = r_root[r_i[1:0]];
    assign w_merge_hit = (r_i != NB_DONE) && (w_mroot != '0) && (w_mroot != r_cur);
    assign w_out_free = !r_res_valid || i_res_ready;
    assign o_pop      = (r_state == S_IDLE) && !i_empty && !i_clr;

    always_comb begin
        w_cur_min = '0;
        for (int k = 0; k < 4; k++) begin
            if (r_root[k] != '0 && (w_cur_min == '0 || r_root[k] < w_cur_min)) begin
                w_cur_min = r_root[k];
            end
        end
    end

    // Box geometry: border, then clip against the frame edge.
    always_comb begin
        w_b   = CALC_W'(i_border);
        w_b2  = CALC_W'({i_border, 1'b0});
        w_mnx = CALC_W'(w_ext_rd.min_x);
        w_mny = CALC_W'(w_ext_rd.min_y);
        w_bx  = (w_mnx > w_b) ? w_mnx - w_b : '0;
        w_by  = (w_mny > w_b) ? w_mny - w_b : '0;
        w_ww  = CALC_W'(w_ext_rd.max_x) - w_mnx + w_b2;
        w_hh  = CALC_W'(w_ext_rd.max_y) - w_mny + w_b2;
        w_box.x = r_bx[ccbb_pkg::BOX_X_W-1:0];
        w_box.y = r_by[ccbb_pkg::BOX_Y_W-1:0];
        w_box.w = r_bw[ccbb_pkg::BOX_W_W-1:0];
        w_box.h = r_bh[ccbb_pkg::BOX_H_W-1:0];
    end

    always_comb begin
        w_line_raddr = (r_state == S_UP) ? r_x + XW'(1) : i_x;
        w_line_we    = (r_state == S_LINE);

        unique case (r_state)
            S_FIND:                      w_par_raddr = r_nb[r_i[1:0]];
            S_FWAIT:                     w_par_raddr = w_par_rdata;
            default:                     w_par_raddr = r_l[LW-1:0];
        endcase
        w_par_we    = 1'b0;
        w_par_waddr = r_next[LW-1:0];
        w_par_wdata = r_next[LW-1:0];
        w_ext_we    = 1'b0;
        w_ext_waddr = r_next[LW-1:0];
        w_ext_wdata = w_pt;
        unique case (r_state)
            S_MIN:   w_ext_raddr = w_cur_min;
            S_MERGE: w_ext_raddr = w_mroot;
            default: w_ext_raddr = r_l[LW-1:0];
        endcase

        if (r_state == S_MIN && w_cur_min == '0 && w_new_ok) begin
            w_par_we = 1'b1;
            w_ext_we = 1'b1;
        end
        if (r_state == S_MERGE && w_merge_hit) begin
            w_par_we    = 1'b1;
            w_par_waddr = w_mroot;
            w_par_wdata = r_cur;
        end
        if (r_state == S_UPD) begin
            w_ext_we    = 1'b1;
            w_ext_waddr = r_cur;
            w_ext_wdata = f_merge(r_acc, w_pt);
        end
    end

    ccbb_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line (
        .i_clk(i_clk), .i_we(w_line_we), .i_waddr(r_x), .i_wdata(r_cur),
        .i_raddr(w_line_raddr), .o_rdata(w_line_rdata)
    );

    ccbb_ram #(.WIDTH(LW), .DEPTH(MAX_LABELS)) u_parent (
        .i_clk(i_clk), .i_we(w_par_we), .i_waddr(w_par_waddr), .i_wdata(w_par_wdata),
        .i_raddr(w_par_raddr), .o_rdata(w_par_rdata)
    );

    ccbb_ram #(.WIDTH(EXW), .DEPTH(MAX_LABELS)) u_extent (
        .i_clk(i_clk), .i_we(w_ext_we), .i_waddr(w_ext_waddr), .i_wdata(w_ext_wdata),
        .i_raddr(w_ext_raddr), .o_rdata(w_ext_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_state    <= S_IDLE;
            r_next     <= NLW'(1);
            r_flag_lab <= 1'b0;
            r_flag_box <= 1'b0;
            r_left     <= '0;
            r_upleft   <= '0;
            r_hold_v   <= 1'b0;
            if (!i_rst_n) begin
                r_res_valid <= 1'b0;
            end
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_x     <= i_x;
                        r_y     <= i_y;
                        r_ctl   <= i_ctl;
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    r_up    <= w_line_rdata;
                    r_state <= S_UR;
                end
                S_UR: begin
                    if (r_ctl.lab) begin
                        r_nb[0] <= w_ur;
                        r_nb[1] <= r_up;
                        r_nb[2] <= r_upleft;
                        r_nb[3] <= r_left;
                        r_i     <= '0;
                        r_state <= S_FIND;
                    end else begin
                        r_cur   <= '0;
                        r_state <= S_LINE;
                    end
                end
                S_FIND: begin
                    if (r_i == NB_DONE) begin
                        r_state <= S_MIN;
                    end else if (r_nb[r_i[1:0]] == '0) begin
                        r_root[r_i[1:0]] <= '0;
                        r_i              <= r_i + 3'd1;
                    end else begin
                        r_walk  <= r_nb[r_i[1:0]];
                        r_state <= S_FWAIT;
                    end
                end
                S_FWAIT: begin
                    // Follow parent links until a label points to itself.
                    if (w_par_rdata == r_walk) begin
                        r_root[r_i[1:0]] <= r_walk;
                        r_i              <= r_i + 3'd1;
                        r_state          <= S_FIND;
                    end else begin
                        r_walk <= w_par_rdata;
                    end
                end
                S_MIN: begin
                    if (w_cur_min == '0) begin
                        if (w_new_ok) begin
                            r_cur  <= r_next[LW-1:0];
                            r_next <= r_next + NLW'(1);
                        end else begin
                            r_cur      <= '0;
                            r_flag_lab <= 1'b1;
                        end
                        r_state <= S_LINE;
                    end else begin
                        r_cur   <= w_cur_min;
                        r_i     <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc   <= w_ext_rd;
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (r_i == NB_DONE) begin
                        r_state <= S_UPD;
                    end else if (w_merge_hit) begin
                        r_state <= S_MWAIT;
                    end else begin
                        r_i <= r_i + 3'd1;
                    end
                end
                S_MWAIT: begin
                    r_acc   <= f_merge(r_acc, w_ext_rd);
                    r_i     <= r_i + 3'd1;
                    r_state <= S_MERGE;
                end
                S_UPD: begin
                    r_state <= S_LINE;
                end
                S_LINE: begin
                    r_upleft <= r_ctl.end_row ? '0 : r_up;
                    r_left   <= r_ctl.end_row ? '0 : r_cur;
                    if (r_ctl.end_frame) begin
                        r_l     <= NLW'(1);
                        r_cnt   <= '0;
                        r_state <= S_CNT_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_CNT_RD: begin
                    if (r_l >= r_next) begin
                        r_flag_box <= (r_cnt > BOX_LIM);
                        r_l        <= NLW'(1);
                        r_chosen   <= '0;
                        r_state    <= S_SEL_RD;
                    end else begin
                        r_state <= S_CNT_CHK;
                    end
                end
                S_CNT_CHK: begin
                    if (w_par_rdata == r_l[LW-1:0] && r_cnt <= BOX_LIM) begin
                        r_cnt <= r_cnt + BW'(1);
                    end
                    r_l     <= r_l + NLW'(1);
                    r_state <= S_CNT_RD;
                end
                S_SEL_RD: begin
                    if (r_l >= r_next || r_chosen == BOX_LIM) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_SEL_CHK;
                    end
                end
                S_SEL_CHK: begin
                    // Roots come in label order, which is first-pixel order.
                    r_l <= r_l + NLW'(1);
                    if (w_par_rdata == r_l[LW-1:0]) begin
                        r_chosen <= r_chosen + BW'(1);
                        r_state  <= S_GEO;
                    end else begin
                        r_state <= S_SEL_RD;
                    end
                end
                S_GEO: begin
                    r_bx    <= w_bx;
                    r_by    <= w_by;
                    r_ww    <= w_ww;
                    r_hh    <= w_hh;
                    r_state <= S_GEO2;
                end
                S_GEO2: begin
                    r_bw    <= (r_bx + r_ww < i_eff_w) ? r_ww : i_eff_w - r_bx;
                    r_bh    <= (r_by + r_hh < i_eff_h) ? r_hh : i_eff_h - r_by;
                    r_state <= S_AREA;
                end
                S_AREA: begin
                    r_area  <= r_bw * r_bh;
                    r_state <= S_KEEP;
                end
                S_KEEP: begin
                    // Hold one kept box back so the last one can be marked.
                    if (r_area < AREA_W'(i_min_area)) begin
                        r_state <= S_SEL_RD;
                    end else if (!r_hold_v) begin
                        r_hold   <= w_box;
                        r_hold_v <= 1'b1;
                        r_state  <= S_SEL_RD;
                    end else if (w_out_free) begin
                        r_res_valid     <= 1'b1;
                        r_res_box       <= r_hold;
                        r_res_box_valid <= 1'b1;
                        r_res_last      <= 1'b0;
                        r_res_lab       <= r_flag_lab;
                        r_res_bov       <= r_flag_box;
                        r_hold          <= w_box;
                        r_state         <= S_SEL_RD;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_res_valid     <= 1'b1;
                        r_res_box       <= r_hold_v ? r_hold : '0;
                        r_res_box_valid <= r_hold_v;
                        r_res_last      <= 1'b1;
                        r_res_lab       <= r_flag_lab;
                        r_res_bov       <= r_flag_box;
                        r_hold_v        <= 1'b0;
                        r_next          <= NLW'(1);
                        r_flag_lab      <= 1'b0;
                        r_flag_box      <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_box            = r_res_box;
    assign o_box_valid      = r_res_box_valid;
    assign o_last_box       = r_res_last;
    assign o_label_overflow = r_res_lab;
    assign o_box_overflow   = r_res_bov;

`ifndef SYNTHESIS
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next != '0) && (r_next <= LAB_LIM))
        else $error("label counter out of range");

    a_chosen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chosen <= BOX_LIM)
        else $error("more boxes chosen than slots");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("held box left over after frame");

    a_parent_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWAIT) |-> (w_par_rdata <= r_walk))
        else $error("parent link points to a larger label");
`endif
endmodule
